// File: hdl/fpalu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpalu_pkg
// Shared constants, types and the divider step for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpalu_pkg;

    // Fraction bits of the fixed-point format
    localparam int FRAC_BITS = 8;

    // Field widths
    localparam int KIND_W = 4;
    localparam int WORD_W = 32;

    // Stream payload widths (zero-filled to whole bytes)
    localparam int S_DATA_W = 64;   // operand_a, operand_b
    localparam int S_USER_W = KIND_W;
    localparam int M_DATA_W = 40;   // value, a_less, a_equal, a_greater, divide_by_zero

    // Scaled dividend width: |operand_a| followed by FRAC_BITS zeros
    localparam int DIV_W = WORD_W + FRAC_BITS;

    // Rounding bias that turns an arithmetic shift into truncation toward zero
    localparam logic [63:0] MUL_BIAS = (64'd1 << FRAC_BITS) - 64'd1;

    // Operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD      = 4'd0,
        KIND_SUB      = 4'd1,
        KIND_MUL      = 4'd2,
        KIND_DIV      = 4'd3,
        KIND_MIN      = 4'd4,
        KIND_MAX      = 4'd5,
        KIND_INC      = 4'd6,
        KIND_DEC      = 4'd7,
        KIND_FROM_INT = 4'd8,
        KIND_TO_INT   = 4'd9,
        KIND_COMPARE  = 4'd10
    } kind_t;

    // Per-item control and result record that travels beside the divider
    typedef struct packed {
        logic              is_mul;
        logic              is_div;
        logic              neg;
        logic              dz;
        logic              less;
        logic              equal;
        logic              greater;
        logic [WORD_W-1:0] value;
    } side_t;

    // Divider state: partial remainder, dividend/quotient shift word, divisor
    typedef struct packed {
        logic [WORD_W-1:0] rem;
        logic [DIV_W-1:0]  dq;
        logic [WORD_W-1:0] den;
    } div_t;

    // One restoring division step: one quotient bit shifts in at the bottom
    function automatic div_t div_step(div_t d);
        logic [WORD_W:0] trial;
        logic [WORD_W:0] diff;
        logic            ge;
        div_t            r;
        trial  = {d.rem, d.dq[DIV_W-1]};
        diff   = trial - {1'b0, d.den};
        ge     = (trial >= {1'b0, d.den});
        r.den  = d.den;
        r.rem  = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        r.dq   = {d.dq[DIV_W-2:0], ge};
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/fixed_point_alu_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_alu_top
// Signed 32-bit fixed-point ALU, fully pipelined, one operation per cycle while the output advances.
// ----------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)                 | tuser
//  s_      | in        | operand_a, operand_b               | kind
//  m_      | out       | value, a_less, a_equal, a_greater, | -
//          |           | divide_by_zero, zero fill          |
//
//  The path runs through the input register, the operand stage, one stage
//  per quotient bit of the restoring divider (DIV_W stages), and the output
//  register. All kinds take the same path length.
//  A new transfer is accepted every cycle while the output advances.
//  When the output register is full and m_tready is low, the whole pipe
//  holds. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module fixed_point_alu_top (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // [31:0] operand_a, [63:32] operand_b
    input  wire [fpalu_pkg::S_DATA_W-1:0] s_tdata,
    // [3:0] kind
    input  wire [fpalu_pkg::S_USER_W-1:0] s_tuser,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // [31:0] value, [32] a_less, [33] a_equal, [34] a_greater,
    // [35] divide_by_zero, [39:36] zero
    output logic [fpalu_pkg::M_DATA_W-1:0] m_tdata
);
    import fpalu_pkg::*;

    // Pipe advance: the output register is free or being emptied
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Input register
    logic [KIND_W-1:0] in_kind_reg;
    logic [WORD_W-1:0] in_a_reg;
    logic [WORD_W-1:0] in_b_reg;
    logic              in_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (adv) begin
            in_vld_reg <= s_tvalid;
        end
        if (adv) begin
            in_kind_reg <= s_tuser;
            in_a_reg    <= s_tdata[WORD_W-1:0];
            in_b_reg    <= s_tdata[2*WORD_W-1:WORD_W];
        end
    end

    // Operand stage: simple results, flags, operand magnitudes, product
    side_t side_next;
    div_t  div_init;

    always_comb begin
        logic              lt;
        logic              eq;
        logic              gt;
        logic [WORD_W-1:0] abs_a;
        logic [WORD_W-1:0] abs_b;
        lt    = $signed(in_a_reg) < $signed(in_b_reg);
        eq    = (in_a_reg == in_b_reg);
        gt    = $signed(in_a_reg) > $signed(in_b_reg);
        abs_a = in_a_reg[WORD_W-1] ? (~in_a_reg + 32'd1) : in_a_reg;
        abs_b = in_b_reg[WORD_W-1] ? (~in_b_reg + 32'd1) : in_b_reg;

        side_next         = '0;
        side_next.less    = lt;
        side_next.equal   = eq;
        side_next.greater = gt;
        side_next.neg     = in_a_reg[WORD_W-1] ^ in_b_reg[WORD_W-1];
        case (in_kind_reg)
            KIND_ADD:      side_next.value = in_a_reg + in_b_reg;
            KIND_SUB:      side_next.value = in_a_reg - in_b_reg;
            KIND_MUL:      side_next.is_mul = 1'b1;
            KIND_DIV: begin
                side_next.is_div = 1'b1;
                side_next.dz     = (in_b_reg == '0);
            end
            KIND_MIN:      side_next.value = lt ? in_a_reg : in_b_reg;
            KIND_MAX:      side_next.value = gt ? in_a_reg : in_b_reg;
            KIND_INC:      side_next.value = in_a_reg + 32'd1;
            KIND_DEC:      side_next.value = in_a_reg - 32'd1;
            KIND_FROM_INT: side_next.value = in_a_reg << FRAC_BITS;
            KIND_TO_INT:   side_next.value = WORD_W'($signed(in_a_reg) >>> FRAC_BITS);
            KIND_COMPARE:  side_next.value = in_a_reg;
            default:       side_next.value = '0;
        endcase

        div_init.rem = '0;
        div_init.dq  = {abs_a, {FRAC_BITS{1'b0}}};
        div_init.den = abs_b;
    end

    // Pipeline registers: index k holds the item after k divider steps
    side_t              side_reg [0:DIV_W];
    div_t               div_reg  [0:DIV_W];
    logic [DIV_W:0]     vld_reg;
    logic signed [63:0] prod_reg;

    // Product scaling: bias negative products so the shift truncates toward zero
    logic [63:0]       prod_sum;
    side_t             side_mul;
    always_comb begin
        prod_sum = prod_reg + (prod_reg[63] ? MUL_BIAS : 64'd0);
        side_mul = side_reg[0];
        if (side_reg[0].is_mul) begin
            side_mul.value = prod_sum[FRAC_BITS+WORD_W-1:FRAC_BITS];
        end
    end

    // Operand stage registers and divider stages, one quotient bit each;
    // the side record rides along
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DIV_W-1:0], in_vld_reg};
        end
        if (adv) begin
            side_reg[0] <= side_next;
            div_reg[0]  <= div_init;
            prod_reg    <= $signed(in_a_reg) * $signed(in_b_reg);
            side_reg[1] <= side_mul;
            div_reg[1]  <= div_step(div_reg[0]);
            for (int k = 2; k <= DIV_W; k++) begin
                side_reg[k] <= side_reg[k-1];
                div_reg[k]  <= div_step(div_reg[k-1]);
            end
        end
    end

    // Final select: signed quotient for div (zero on divide by zero), else the carried value
    logic [WORD_W-1:0] quot;
    logic [WORD_W-1:0] value_fin;
    always_comb begin
        quot = div_reg[DIV_W].dq[WORD_W-1:0];
        if (!side_reg[DIV_W].is_div) begin
            value_fin = side_reg[DIV_W].value;
        end else if (side_reg[DIV_W].dz) begin
            value_fin = '0;
        end else if (side_reg[DIV_W].neg) begin
            value_fin = ~quot + 32'd1;
        end else begin
            value_fin = quot;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (adv) begin
            m_tvalid <= vld_reg[DIV_W];
        end
        if (adv) begin
            m_tdata <= {4'b0000,
                        side_reg[DIV_W].dz,
                        side_reg[DIV_W].greater,
                        side_reg[DIV_W].equal,
                        side_reg[DIV_W].less,
                        value_fin};
        end
    end

endmodule
`default_nettype wire
